>>> rtl/core/bgd_pkg.sv
// ----------------------------------------------------------------------------
// bgd_pkg
// Shared types, constants and helpers of the button gesture detector.
// ----------------------------------------------------------------------------
package bgd_pkg;

    localparam int NUM_BUTTONS = 8;
    localparam int SLOT_W      = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int CNT_W       = 16;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

    localparam logic [CNT_W-1:0] RST_CLICK_MAX   = 16'h4000;
    localparam logic [CNT_W-1:0] RST_DBCLICK_GAP = 16'h0050;
    localparam logic [CNT_W-1:0] RST_LONG_PRESS  = 16'hA000;
    localparam logic [CNT_W-1:0] RST_REPEAT      = 16'h1000;

    typedef logic [SLOT_W-1:0] t_slot;

    typedef enum logic [2:0] {
        REG_CLICK_MAX   = 3'd0,
        REG_DBCLICK_GAP = 3'd1,
        REG_LONG_PRESS  = 3'd2,
        REG_REPEAT      = 3'd3,
        REG_DBL_ENABLE  = 3'd4,
        REG_PRESS_LEVEL = 3'd5
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_PRESS1 = 3'd1,
        ST_LONG   = 3'd2,
        ST_GAP    = 3'd3,
        ST_PRESS2 = 3'd4
    } t_gstate;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_CLICK   = 3'd1,
        EV_DBCLICK = 3'd2,
        EV_LONG    = 3'd3,
        EV_REPEAT  = 3'd4
    } t_event;

    typedef struct packed {
        logic [2:0] button_index;
        logic       key_level;
    } t_in_item;

    typedef struct packed {
        logic [2:0] event_button;
        logic [2:0] event_code;
    } t_out_item;

    typedef struct packed {
        logic [CNT_W-1:0] click_max;
        logic [CNT_W-1:0] dbclick_gap;
        logic [CNT_W-1:0] long_press;
        logic [CNT_W-1:0] repeat_ticks;
        logic             dbl_enable;
        logic             pressed_level;
    } t_cfg;

    typedef struct packed {
        t_gstate          gstate;
        logic [CNT_W-1:0] press_ticks;
        logic [CNT_W-1:0] gap_ticks;
        logic [CNT_W-1:0] second_ticks;
    } t_btn_entry;

    localparam t_btn_entry BTN_RESET = '{
        gstate:       ST_IDLE,
        press_ticks:  '0,
        gap_ticks:    '0,
        second_ticks: '0
    };

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v != CNT_MAX) ? v + 1'b1 : v;
    endfunction

    function automatic logic slot_valid(input logic [2:0] idx);
        return 32'(idx) < NUM_BUTTONS;
    endfunction

endpackage

>>> rtl/core/bgd_cfg.sv
// ----------------------------------------------------------------------------
// bgd_cfg
// APB register file holding the gesture timing limits and mode bits.
// ----------------------------------------------------------------------------
module bgd_cfg import bgd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                REG_CLICK_MAX:   n_cfg.click_max     = pwdata[CNT_W-1:0];
                REG_DBCLICK_GAP: n_cfg.dbclick_gap   = pwdata[CNT_W-1:0];
                REG_LONG_PRESS:  n_cfg.long_press    = pwdata[CNT_W-1:0];
                REG_REPEAT:      n_cfg.repeat_ticks  = pwdata[CNT_W-1:0];
                REG_DBL_ENABLE:  n_cfg.dbl_enable    = pwdata[0];
                REG_PRESS_LEVEL: n_cfg.pressed_level = pwdata[0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CLICK_MAX:   prdata = DATA_W'(r_cfg.click_max);
            REG_DBCLICK_GAP: prdata = DATA_W'(r_cfg.dbclick_gap);
            REG_LONG_PRESS:  prdata = DATA_W'(r_cfg.long_press);
            REG_REPEAT:      prdata = DATA_W'(r_cfg.repeat_ticks);
            REG_DBL_ENABLE:  prdata = DATA_W'(r_cfg.dbl_enable);
            REG_PRESS_LEVEL: prdata = DATA_W'(r_cfg.pressed_level);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{
                click_max:     RST_CLICK_MAX,
                dbclick_gap:   RST_DBCLICK_GAP,
                long_press:    RST_LONG_PRESS,
                repeat_ticks:  RST_REPEAT,
                dbl_enable:    1'b0,
                pressed_level: 1'b0
            };
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

>>> rtl/core/bgd_fsm.sv
// ----------------------------------------------------------------------------
// bgd_fsm
// One step of the per-button gesture machine: next state, counters, event.
// ----------------------------------------------------------------------------
module bgd_fsm import bgd_pkg::*; (
    input  t_btn_entry i_cur,
    input  t_cfg       i_cfg,
    input  logic       i_down,
    output t_btn_entry o_next,
    output t_event     o_event
);

    logic [CNT_W-1:0] press_inc;
    logic [CNT_W-1:0] gap_inc;
    logic [CNT_W-1:0] second_inc;

    assign press_inc  = sat_inc(i_cur.press_ticks);
    assign gap_inc    = sat_inc(i_cur.gap_ticks);
    assign second_inc = sat_inc(i_cur.second_ticks);

    // next state and counters
    always_comb begin
        o_next = i_cur;
        case (i_cur.gstate)
            ST_PRESS1: begin
                if (i_down) begin
                    o_next.press_ticks = press_inc;
                    if (press_inc >= i_cfg.long_press) begin
                        o_next.press_ticks = '0;
                        o_next.gstate      = ST_LONG;
                    end
                end else if (i_cur.press_ticks > i_cfg.click_max) begin
                    o_next.gstate = ST_IDLE;
                end else begin
                    o_next.gap_ticks = '0;
                    o_next.gstate    = ST_GAP;
                end
            end
            ST_LONG: begin
                if (i_down) begin
                    o_next.press_ticks = (press_inc >= i_cfg.repeat_ticks) ? '0 : press_inc;
                end else begin
                    o_next.gstate = ST_IDLE;
                end
            end
            ST_GAP: begin
                if (!i_down) begin
                    o_next.gap_ticks = gap_inc;
                    if (gap_inc > i_cfg.dbclick_gap) begin
                        o_next.gstate = ST_IDLE;
                    end
                end else if (i_cfg.dbl_enable) begin
                    o_next.second_ticks = '0;
                    o_next.gstate       = ST_PRESS2;
                end
            end
            ST_PRESS2: begin
                if (i_cfg.dbl_enable && i_down) begin
                    o_next.second_ticks = second_inc;
                end else begin
                    o_next.gstate = ST_IDLE;
                end
            end
            default: begin
                // idle, and unused codes behave as idle
                o_next.gstate = ST_IDLE;
                if (i_down) begin
                    o_next.press_ticks = '0;
                    o_next.gstate      = ST_PRESS1;
                end
            end
        endcase
    end

    // event output
    always_comb begin
        o_event = EV_NONE;
        case (i_cur.gstate)
            ST_PRESS1: begin
                if (i_down && press_inc >= i_cfg.long_press) begin
                    o_event = EV_LONG;
                end
            end
            ST_LONG: begin
                if (i_down && press_inc >= i_cfg.repeat_ticks) begin
                    o_event = EV_REPEAT;
                end
            end
            ST_GAP: begin
                if (!i_down && gap_inc > i_cfg.dbclick_gap) begin
                    o_event = EV_CLICK;
                end
            end
            ST_PRESS2: begin
                if (i_cfg.dbl_enable && !i_down && i_cur.second_ticks <= i_cfg.click_max) begin
                    o_event = EV_DBCLICK;
                end
            end
            default: o_event = EV_NONE;
        endcase
    end

endmodule

>>> rtl/core/button_gesture_detector.sv
// ----------------------------------------------------------------------------
// button_gesture_detector
// Per-button click, double click, long press and repeat detection.
// ----------------------------------------------------------------------------
// Takes one scan tick request per clock while o_in_stall is low, and gives
// exactly one result per request, passed through the input register, then
// the result register. The per-button state and counters sit in flip-flops
// and are read, stepped and written back in the same cycle that the result
// register is loaded, so ticks for the same button may run back to back.
// Ticks for an index at or above the button count return no event.
module button_gesture_detector import bgd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg       cfg;
    t_in_item   r_in;
    logic       r_in_valid;
    t_out_item  r_out;
    logic       r_out_valid;
    t_btn_entry r_btn [NUM_BUTTONS];

    logic       out_blocked;
    logic       in_load;
    logic       fire;
    logic       idx_ok;
    t_slot      slot;
    logic       down;
    t_btn_entry cur_entry;
    t_btn_entry n_entry;
    t_event     ev;

    bgd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign out_blocked = r_out_valid && i_out_stall;
    assign o_in_stall  = r_in_valid && out_blocked;
    assign in_load     = i_in_valid && !o_in_stall;
    assign fire        = r_in_valid && !out_blocked;

    assign idx_ok    = slot_valid(r_in.button_index);
    assign slot      = SLOT_W'(r_in.button_index);
    assign down      = (r_in.key_level == cfg.pressed_level);
    assign cur_entry = idx_ok ? r_btn[slot] : BTN_RESET;

    bgd_fsm u_fsm (
        .i_cur   (cur_entry),
        .i_cfg   (cfg),
        .i_down  (down),
        .o_next  (n_entry),
        .o_event (ev)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (!out_blocked) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in <= i_in_data;
        end
        if (fire) begin
            r_out.event_button <= r_in.button_index;
            r_out.event_code   <= idx_ok ? ev : EV_NONE;
        end
    end

    // per-button state store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_btn[i] <= BTN_RESET;
            end
        end else if (fire && idx_ok) begin
            r_btn[slot] <= n_entry;
        end
    end

`ifndef ASSERT_OFF
    a_in_moves_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("accepted tick did not reach the result register");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with an empty input register");

    a_long_enters_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && idx_ok && ev == EV_LONG) |=> r_btn[$past(slot)].gstate == ST_LONG)
        else $error("long press event without long press state");

    a_repeat_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && idx_ok && (ev == EV_LONG || ev == EV_REPEAT))
            |=> r_btn[$past(slot)].press_ticks == '0)
        else $error("press counter not cleared after long press event");

    a_bad_index_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !idx_ok) |=> r_out.event_code == EV_NONE)
        else $error("event reported for a button beyond the button count");
`endif

endmodule

>>> tb/tb_button_gesture_detector.sv
// ----------------------------------------------------------------------------
// tb_button_gesture_detector
// Self-checking bench for the per-button click, double click and long press
// detector. Scan ticks go in through a valid/stall port with random gaps, and
// results come back through a randomly stalled port. Each accepted tick steps
// a local gesture predictor, and each result is compared with the oldest
// predicted event. A short scripted table comes first, then phases of random
// gesture sequences under several register settings, extremes included.
// ----------------------------------------------------------------------------
module tb_button_gesture_detector;
    import bgd_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int DRAIN_CYCLES = 10;
    localparam int PHASE_TICKS = 275;

    // directed table rows
    localparam bit TICK = 1'b0;
    localparam bit CFG = 1'b1;
    localparam bit PRED = 1'b0;
    localparam bit TYPED = 1'b1;
    // pressed level stays at its reset value (0) through the table
    localparam logic KEY_DN = 1'b0;
    localparam logic KEY_UP = 1'b1;

    typedef struct packed {
        bit         is_cfg;
        t_reg_idx   reg_sel;
        logic [15:0] value;
        logic [2:0] button;
        logic       level;
        bit         typed;
        t_event     code;
    } t_plan_row;

    localparam int PLAN_LEN = 30;
    localparam t_plan_row PLAN [PLAN_LEN] = '{
        '{TICK, REG_CLICK_MAX, 16'h0000, 3'd0, KEY_UP, TYPED, EV_NONE},
        '{CFG, REG_CLICK_MAX, 16'h0000, 3'd0, KEY_UP, PRED, EV_NONE},
        '{CFG, REG_DBCLICK_GAP, 16'h0000, 3'd0, KEY_UP, PRED, EV_NONE},
        '{CFG, REG_LONG_PRESS, 16'h0002, 3'd0, KEY_UP, PRED, EV_NONE},
        '{CFG, REG_REPEAT, 16'h0001, 3'd0, KEY_UP, PRED, EV_NONE},
        '{CFG, REG_DBL_ENABLE, 16'h0001, 3'd0, KEY_UP, PRED, EV_NONE},
        // single click on the top button
        '{TICK, REG_CLICK_MAX, 16'h0000, 3'd7, KEY_DN, TYPED, EV_NONE},
        '{TICK, REG_CLICK_MAX, 16'h0000, 3'd7, KEY_UP, PRED, EV_NONE},
        '{TICK, REG_CLICK_MAX, 16'h0000, 3'd7, KEY_UP, PRED, EV_NONE},
        // double click
        '{TICK, REG_CLICK_MAX, 16'h0000, 3'd3, KEY_DN, PRED, EV_NONE},
        '{TICK, REG_CLICK_MAX, 16'h0000, 3'd3, KEY_UP, PRED, EV_NONE},
        '{TICK, REG_CLICK_MAX, 16'h0000, 3'd3, KEY_DN, PRED, EV_NONE},
        '{TICK, REG_CLICK_MAX, 16'h0000, 3'd3, KEY_UP, PRED, EV_NONE},
        // long press, one repeat, release with no event
        '{TICK, REG_CLICK_MAX, 16'h0000, 3'd5, KEY_DN, PRED, EV_NONE},
        '{TICK, REG_CLICK_MAX, 16'h0000, 3'd5, KEY_DN, PRED, EV_NONE},
        '{TICK, REG_CLICK_MAX, 16'h0000, 3'd5, KEY_DN, PRED, EV_NONE},
        '{TICK, REG_CLICK_MAX, 16'h0000, 3'd5, KEY_DN, PRED, EV_NONE},
        '{TICK, REG_CLICK_MAX, 16'h0000, 3'd5, KEY_UP, PRED, EV_NONE},
        // press too long for a click
        '{TICK, REG_CLICK_MAX, 16'h0000, 3'd1, KEY_DN, PRED, EV_NONE},
        '{TICK, REG_CLICK_MAX, 16'h0000, 3'd1, KEY_DN, PRED, EV_NONE},
        '{TICK, REG_CLICK_MAX, 16'h0000, 3'd1, KEY_UP, PRED, EV_NONE},
        // second press in flight when double click gets switched off
        '{TICK, REG_CLICK_MAX, 16'h0000, 3'd4, KEY_DN, PRED, EV_NONE},
        '{TICK, REG_CLICK_MAX, 16'h0000, 3'd4, KEY_UP, PRED, EV_NONE},
        '{TICK, REG_CLICK_MAX, 16'h0000, 3'd4, KEY_DN, PRED, EV_NONE},
        '{CFG, REG_DBL_ENABLE, 16'h0000, 3'd0, KEY_UP, PRED, EV_NONE},
        '{TICK, REG_CLICK_MAX, 16'h0000, 3'd4, KEY_DN, PRED, EV_NONE},
        // press during the gap with double click off holds the gap count
        '{TICK, REG_CLICK_MAX, 16'h0000, 3'd2, KEY_DN, PRED, EV_NONE},
        '{TICK, REG_CLICK_MAX, 16'h0000, 3'd2, KEY_UP, PRED, EV_NONE},
        '{TICK, REG_CLICK_MAX, 16'h0000, 3'd2, KEY_DN, PRED, EV_NONE},
        '{TICK, REG_CLICK_MAX, 16'h0000, 3'd2, KEY_UP, PRED, EV_NONE}
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    t_in_item          i_in_data;
    logic              o_out_valid;
    logic              i_out_stall;
    t_out_item         o_out_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    button_gesture_detector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // gesture predictor state and its copy of the registers
    t_cfg             gest_cfg;
    t_gstate          btn_st     [NUM_BUTTONS];
    logic [CNT_W-1:0] press_cnt  [NUM_BUTTONS];
    logic [CNT_W-1:0] gap_cnt    [NUM_BUTTONS];
    logic [CNT_W-1:0] second_cnt [NUM_BUTTONS];

    t_out_item event_q [$];
    int        n_bad;
    int        cycle_cnt;
    bit        tx_idle;
    bit        rx_idle;
    int        hold_req;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic void report_bad(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
        n_bad++;
        if (n_bad <= 10) begin
            $display("mismatch %0d: %s expected %0h got %0h", n_bad, what, want, got);
        end
    endfunction

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 16'd1;
    endfunction

    function automatic t_event gesture_step(input t_in_item it);
        t_event ev;
        logic   down;
        int     b;
        ev = EV_NONE;
        b = int'(it.button_index);
        down = (it.key_level == gest_cfg.pressed_level);
        if (b >= NUM_BUTTONS) return EV_NONE;
        case (btn_st[b])
            ST_PRESS1: begin
                if (down) begin
                    press_cnt[b] = bump(press_cnt[b]);
                    if (press_cnt[b] >= gest_cfg.long_press) begin
                        press_cnt[b] = '0;
                        btn_st[b] = ST_LONG;
                        ev = EV_LONG;
                    end
                end else if (press_cnt[b] > gest_cfg.click_max) begin
                    btn_st[b] = ST_IDLE;
                end else begin
                    gap_cnt[b] = '0;
                    btn_st[b] = ST_GAP;
                end
            end
            ST_LONG: begin
                if (down) begin
                    press_cnt[b] = bump(press_cnt[b]);
                    if (press_cnt[b] >= gest_cfg.repeat_ticks) begin
                        press_cnt[b] = '0;
                        ev = EV_REPEAT;
                    end
                end else begin
                    btn_st[b] = ST_IDLE;
                end
            end
            ST_GAP: begin
                if (!down) begin
                    gap_cnt[b] = bump(gap_cnt[b]);
                    if (gap_cnt[b] > gest_cfg.dbclick_gap) begin
                        btn_st[b] = ST_IDLE;
                        ev = EV_CLICK;
                    end
                end else if (gest_cfg.dbl_enable) begin
                    second_cnt[b] = '0;
                    btn_st[b] = ST_PRESS2;
                end
            end
            ST_PRESS2: begin
                if (!gest_cfg.dbl_enable) begin
                    btn_st[b] = ST_IDLE;
                end else if (down) begin
                    second_cnt[b] = bump(second_cnt[b]);
                end else begin
                    btn_st[b] = ST_IDLE;
                    if (second_cnt[b] <= gest_cfg.click_max) ev = EV_DBCLICK;
                end
            end
            default: begin
                btn_st[b] = ST_IDLE;
                if (down) begin
                    press_cnt[b] = '0;
                    btn_st[b] = ST_PRESS1;
                end
            end
        endcase
        return ev;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_tick(input t_in_item it, input bit typed, input t_event typed_code);
        int        wait_cycles;
        t_out_item want;
        wait_cycles = tx_idle ? $urandom_range(0, 3) : 0;
        if (wait_cycles > 0) begin
            i_in_valid <= 1'b0;
            repeat (wait_cycles) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
        want.event_button = it.button_index;
        want.event_code = gesture_step(it);
        if (typed) want.event_code = typed_code;
        event_q.push_back(want);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (event_q.size() != 0) @(posedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // write with a setup phase and an access phase, then read the register back
    task automatic cfg_write(input t_reg_idx r, input logic [15:0] v);
        logic [DATA_W-1:0] want_rd;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({r, 2'b00});
        pwdata <= DATA_W'(v);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        case (r)
            REG_CLICK_MAX:   gest_cfg.click_max = v;
            REG_DBCLICK_GAP: gest_cfg.dbclick_gap = v;
            REG_LONG_PRESS:  gest_cfg.long_press = v;
            REG_REPEAT:      gest_cfg.repeat_ticks = v;
            REG_DBL_ENABLE:  gest_cfg.dbl_enable = v[0];
            REG_PRESS_LEVEL: gest_cfg.pressed_level = v[0];
            default: ;
        endcase
        want_rd = (r == REG_DBL_ENABLE || r == REG_PRESS_LEVEL) ? {31'b0, v[0]} : {16'b0, v};
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== want_rd) report_bad("register readback", want_rd, prdata);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_setting(input logic [15:0] click, input logic [15:0] gap,
                                 input logic [15:0] long_t, input logic [15:0] rep,
                                 input logic dbl, input logic lvl);
        settle();
        cfg_write(REG_CLICK_MAX, click);
        cfg_write(REG_DBCLICK_GAP, gap);
        cfg_write(REG_LONG_PRESS, long_t);
        cfg_write(REG_REPEAT, rep);
        cfg_write(REG_DBL_ENABLE, {15'b0, dbl});
        cfg_write(REG_PRESS_LEVEL, {15'b0, lvl});
    endtask

    // mostly press/release runs on one button, some single noise ticks between
    task automatic play_gestures(input int n_ticks);
        int       sent;
        int       runs;
        int       len;
        t_in_item it;
        sent = 0;
        while (sent < n_ticks) begin
            if ($urandom_range(0, 99) < 15) begin
                it.button_index = 3'($urandom_range(0, 7));
                it.key_level = 1'($urandom_range(0, 1));
                send_tick(it, PRED, EV_NONE);
                sent++;
            end else begin
                it.button_index = 3'($urandom_range(0, 7));
                it.key_level = gest_cfg.pressed_level;
                runs = $urandom_range(1, 4);
                repeat (runs) begin
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40)
                                                     : $urandom_range(1, 10);
                    repeat (len) begin
                        send_tick(it, PRED, EV_NONE);
                        sent++;
                    end
                    it.key_level = ~it.key_level;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (event_q.size() == 0) begin
                report_bad("result with nothing pending", '0, 32'(o_out_data));
            end else begin
                want = event_q.pop_front();
                if (o_out_data.event_button !== want.event_button) begin
                    report_bad("event_button", 32'(want.event_button),
                               32'(o_out_data.event_button));
                end
                if (o_out_data.event_code !== want.event_code) begin
                    report_bad("event_code", 32'(want.event_code), 32'(o_out_data.event_code));
                end
            end
        end
    end

    // result side stall: a drawn wait per result, plus long holds on request
    initial begin : result_stall
        bit took;
        int stall_cnt;
        i_out_stall = 1'b0;
        stall_cnt = 0;
        forever begin
            @(posedge i_clk);
            took = i_rst_n && o_out_valid && !i_out_stall;
            @(negedge i_clk);
            if (hold_req > 0) begin
                stall_cnt = hold_req;
                hold_req = 0;
            end else if (took) begin
                stall_cnt = rx_idle ? $urandom_range(0, 3) : 0;
            end
            if (stall_cnt > 0) begin
                i_out_stall <= 1'b1;
                stall_cnt--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : main
        t_in_item it;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        n_bad = 0;
        cycle_cnt = 0;
        hold_req = 0;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        gest_cfg = '{click_max: RST_CLICK_MAX, dbclick_gap: RST_DBCLICK_GAP,
                     long_press: RST_LONG_PRESS, repeat_ticks: RST_REPEAT,
                     dbl_enable: 1'b0, pressed_level: 1'b0};
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            btn_st[i] = ST_IDLE;
            press_cnt[i] = '0;
            gap_cnt[i] = '0;
            second_cnt[i] = '0;
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < PLAN_LEN; i++) begin
            if (PLAN[i].is_cfg) begin
                settle();
                cfg_write(PLAN[i].reg_sel, PLAN[i].value);
            end else begin
                it.button_index = PLAN[i].button;
                it.key_level = PLAN[i].level;
                send_tick(it, PLAN[i].typed, PLAN[i].code);
            end
        end

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin
                    apply_setting(16'($urandom_range(1, 8)), 16'($urandom_range(1, 6)),
                                  16'($urandom_range(4, 16)), 16'($urandom_range(1, 6)),
                                  1'b1, 1'b1);
                    tx_idle = 1'b1;
                    rx_idle = 1'b1;
                end
                1: begin
                    apply_setting(16'($urandom_range(1, 8)), 16'($urandom_range(1, 6)),
                                  16'($urandom_range(4, 16)), 16'($urandom_range(1, 6)),
                                  1'b0, 1'b0);
                end
                2: begin
                    apply_setting(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1);
                    // sender keeps pushing while results are held back
                    tx_idle = 1'b0;
                    hold_req = 80;
                end
                3: begin
                    apply_setting(CNT_MAX, 16'h0000, CNT_MAX, CNT_MAX, 1'b1, 1'b0);
                    tx_idle = 1'b1;
                end
                4: begin
                    apply_setting(16'($urandom_range(1, 8)), 16'($urandom_range(1, 6)),
                                  16'($urandom_range(4, 16)), 16'($urandom_range(1, 6)),
                                  1'b1, 1'b0);
                    tx_idle = 1'b0;
                    rx_idle = 1'b0;
                end
                default: begin
                    apply_setting(16'($urandom_range(0, 8)), CNT_MAX,
                                  16'($urandom_range(1, 4)), 16'h0000, 1'b0, 1'b1);
                    tx_idle = 1'b1;
                    rx_idle = 1'b1;
                end
            endcase
            play_gestures(PHASE_TICKS);
        end

        i_in_valid <= 1'b0;
        while (event_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_bad == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/bgd_pkg.sv
rtl/core/bgd_cfg.sv
rtl/core/bgd_fsm.sv
rtl/core/button_gesture_detector.sv
tb/tb_button_gesture_detector.sv
